// ===== hdl/fras_pkg.sv =====
// ----------------------------------------------------------------------------
// fras_pkg
// Shared constants and types for the framed register access slave.
// ----------------------------------------------------------------------------
package fras_pkg;

  localparam logic [7:0] SYM_START   = 8'h24;  // '$'
  localparam logic [7:0] SYM_NL      = 8'h0A;  // newline
  localparam logic [7:0] SYM_WRITE   = 8'h57;  // 'W'
  localparam logic [7:0] SYM_READ    = 8'h52;  // 'R'
  localparam logic [7:0] ID_AT_RESET = 8'h01;

  localparam int FRAME_LIMIT_DEF = 16;
  localparam int REG_COUNT_DEF   = 16;
  localparam int HELD_BYTES      = 5;
  localparam int QUEUE_DEPTH     = 2;
  localparam int REPLY_LEN       = 7;

  // a checked frame, ready to be carried out
  typedef struct packed {
    logic       is_wr;
    logic [7:0] id;
    logic [7:0] addr;
    logic [7:0] data;
  } cmd_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/fras_front.sv =====
// ----------------------------------------------------------------------------
// fras_front
// Gathers received bytes into a frame and checks it when the newline arrives.
// ----------------------------------------------------------------------------
module fras_front #(
  parameter int FRAME_LIMIT = fras_pkg::FRAME_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  logic [7:0]       own_id,
  input  fras_pkg::q_stat_t q_stat,
  output logic             push,
  output fras_pkg::cmd_t   push_cmd
);

  localparam int CW = $clog2(FRAME_LIMIT + 1);
  localparam int HW = $clog2(fras_pkg::HELD_BYTES);

  logic          recv_r, recv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    held_r [fras_pkg::HELD_BYTES];

  logic       accept;
  logic       at_limit;
  logic       store;
  logic [7:0] wr_sum, rd_sum;
  logic       wr_ok, rd_ok;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign at_limit = (cnt_r == CW'(FRAME_LIMIT));

  // byte positions 1..5 are the only ones needed for checking
  assign store = accept && recv_r && !at_limit &&
                 (cnt_r >= CW'(1)) && (cnt_r <= CW'(fras_pkg::HELD_BYTES));

  assign wr_sum = held_r[0] + held_r[1] + held_r[2] + held_r[3];
  assign rd_sum = held_r[0] + held_r[1] + held_r[2];

  // count still holds the length before the newline
  assign wr_ok = (cnt_r == CW'(6)) && (held_r[1] == fras_pkg::SYM_WRITE) &&
                 (wr_sum == held_r[4]);
  assign rd_ok = (cnt_r == CW'(5)) && (held_r[1] == fras_pkg::SYM_READ) &&
                 (rd_sum == held_r[3]);

  always_comb begin
    recv_nxt = recv_r;
    cnt_nxt  = cnt_r;
    push     = 1'b0;
    if (accept) begin
      if (!recv_r) begin
        if (in_rx_byte == fras_pkg::SYM_START) begin
          recv_nxt = 1'b1;
          cnt_nxt  = CW'(1);
        end
      end else if (at_limit) begin
        recv_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
        if (in_rx_byte == fras_pkg::SYM_NL) begin
          recv_nxt = 1'b0;
          push     = (held_r[0] == own_id) && (wr_ok || rd_ok);
        end
      end
    end
  end

  assign push_cmd.is_wr = (held_r[1] == fras_pkg::SYM_WRITE);
  assign push_cmd.id    = held_r[0];
  assign push_cmd.addr  = held_r[2];
  assign push_cmd.data  = held_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      recv_r <= recv_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      held_r[HW'(cnt_r - CW'(1))] <= in_rx_byte;
    end
  end

endmodule

// ===== hdl/fras_queue.sv =====
// ----------------------------------------------------------------------------
// fras_queue
// Short command queue between the frame checker and the register engine.
// ----------------------------------------------------------------------------
module fras_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fras_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output fras_pkg::cmd_t    pop_cmd,
  output fras_pkg::q_stat_t q_stat
);

  localparam int DEPTH = fras_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  fras_pkg::cmd_t ent_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_cmd      = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/fras_back.sv =====
// ----------------------------------------------------------------------------
// fras_back
// Carries out one command on the register store and sends the 7-byte reply.
// ----------------------------------------------------------------------------
module fras_back #(
  parameter int REG_COUNT = fras_pkg::REG_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fras_pkg::q_stat_t q_stat,
  input  fras_pkg::cmd_t    pop_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_tx_byte,
  output logic              out_tx_last
);

  localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int BW = $clog2(fras_pkg::REPLY_LEN);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  state_t         state_r;
  logic [BW-1:0]  idx_r;
  fras_pkg::cmd_t cur_r;
  logic           ov_r;
  logic [7:0]     ob_r;
  logic           ol_r;

  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [7:0]           rd_r;
  logic                 rd_ok_r;

  logic          in_rng;
  logic [IW-1:0] ra;
  logic          wr_en;
  logic          load;
  logic [7:0]    data;
  logic [7:0]    cmd_sym;
  logic [7:0]    sum;
  logic [7:0]    byte_sel;

  assign pop    = (state_r == ST_IDLE) && !q_stat.empty;
  assign in_rng = ({1'b0, pop_cmd.addr} < 9'(REG_COUNT));
  assign ra     = pop_cmd.addr[IW-1:0];
  assign wr_en  = pop && pop_cmd.is_wr && in_rng;
  assign load   = (state_r == ST_SEND) && (!ov_r || out_ready);

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[ra] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ra] <= pop_cmd.data;
    end
    if (pop) begin
      rd_r    <= mem[ra];
      rd_ok_r <= in_rng && vld_r[ra];
    end
  end

  assign data    = cur_r.is_wr ? cur_r.data : (rd_ok_r ? rd_r : 8'h00);
  assign cmd_sym = cur_r.is_wr ? fras_pkg::SYM_WRITE : fras_pkg::SYM_READ;
  assign sum     = cur_r.id + cmd_sym + cur_r.addr + data;

  always_comb begin
    unique case (idx_r)
      BW'(0):  byte_sel = fras_pkg::SYM_START;
      BW'(1):  byte_sel = cur_r.id;
      BW'(2):  byte_sel = cmd_sym;
      BW'(3):  byte_sel = cur_r.addr;
      BW'(4):  byte_sel = data;
      BW'(5):  byte_sel = sum;
      default: byte_sel = fras_pkg::SYM_NL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (ov_r && out_ready && !load) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            cur_r   <= pop_cmd;
            idx_r   <= '0;
            state_r <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (load) begin
            ov_r  <= 1'b1;
            ob_r  <= byte_sel;
            ol_r  <= (idx_r == BW'(fras_pkg::REPLY_LEN - 1));
            idx_r <= idx_r + BW'(1);
            if (idx_r == BW'(fras_pkg::REPLY_LEN - 1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid   = ov_r;
  assign out_tx_byte = ob_r;
  assign out_tx_last = ol_r;

endmodule

// ===== hdl/framed_register_access_slave_top.sv =====
// ----------------------------------------------------------------------------
// framed_register_access_slave_top
// Byte-stream slave that decodes '$'-framed read/write commands on a
// register store and answers each good frame with a 7-byte reply.
// ----------------------------------------------------------------------------
// One received byte is taken per clock. When a newline closes a good frame,
// the checked command goes into a two-entry queue; the register engine takes
// it out into its command register, accesses the store and then sends the
// reply one byte per cycle from an output register while the receiver is
// ready. Input is held off only while the command queue is full,
// which happens when replies are back-pressured for longer than new frames
// take to arrive. The register store clears at reset through per-entry valid
// bits, so no clearing pass is needed.
module framed_register_access_slave_top #(
  parameter int FRAME_LIMIT = fras_pkg::FRAME_LIMIT_DEF,
  parameter int REG_COUNT   = fras_pkg::REG_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_own_slave_id
);

  logic [7:0]        own_id_r;
  fras_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;
  fras_pkg::cmd_t    push_cmd;
  fras_pkg::cmd_t    pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= fras_pkg::ID_AT_RESET;
    end else if (cfg_wr_en) begin
      own_id_r <= cfg_own_slave_id;
    end
  end

  fras_front #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .own_id     (own_id_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  fras_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  fras_back #(
    .REG_COUNT (REG_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .pop_cmd     (pop_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_tx_byte (out_tx_byte),
    .out_tx_last (out_tx_last)
  );

  a_last_is_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_last |-> out_tx_byte == fras_pkg::SYM_NL)
    else $error("reply end byte is not a newline");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("command popped from an empty queue");

  a_reply_owner: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_cmd.id == own_id_r)
    else $error("queued command for another slave id");

endmodule

// ===== test/tb_framed_register_access_slave_top.sv =====
// ----------------------------------------------------------------------------
// tb_framed_register_access_slave_top
// Self-checking bench for the framed register access slave: streams directed
// and random '$'-framed command bytes through the receive channel, models the
// frame decoder and register store to build the expected 7-byte replies, and
// compares every reply byte under varying idle and back-pressure patterns.
// ----------------------------------------------------------------------------
module tb_framed_register_access_slave_top;

  localparam int FRAME_LIMIT    = fras_pkg::FRAME_LIMIT_DEF;
  localparam int REG_COUNT      = fras_pkg::REG_COUNT_DEF;
  localparam int PHASE_ITEMS    = 24;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [7:0] tx_byte;
    logic       tx_last;
  } reply_byte_t;

  typedef enum {BAD_ID, BAD_SUM, BAD_LEN, BAD_CMD} frame_fault_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_tx_byte;
  logic       out_tx_last;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_own_slave_id = 8'h00;

  // stimulus and expectations
  logic [7:0]  rx_stim_q[$];
  reply_byte_t reply_exp_q[$];
  reply_byte_t reply_exp;
  int unsigned items_pushed = 0;
  int unsigned items_accepted = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          progress;

  // decoder and register store model
  logic [7:0]  own_id_q = fras_pkg::ID_AT_RESET;
  bit          rx_active = 1'b0;
  int unsigned rx_count = 0;
  logic [7:0]  held[fras_pkg::HELD_BYTES];
  logic [7:0]  regs[REG_COUNT];

  framed_register_access_slave_top #(
    .FRAME_LIMIT(FRAME_LIMIT),
    .REG_COUNT  (REG_COUNT)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tx_byte     (out_tx_byte),
    .out_tx_last     (out_tx_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_own_slave_id(cfg_own_slave_id)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void queue_reply(input logic [7:0] id, cmd, addr, data);
    logic [7:0] bytes[fras_pkg::REPLY_LEN];
    reply_byte_t r;
    bytes[0] = fras_pkg::SYM_START;
    bytes[1] = id;
    bytes[2] = cmd;
    bytes[3] = addr;
    bytes[4] = data;
    bytes[5] = id + cmd + addr + data;
    bytes[6] = fras_pkg::SYM_NL;
    for (int k = 0; k < fras_pkg::REPLY_LEN; k++) begin
      r.tx_byte = bytes[k];
      r.tx_last = (k == fras_pkg::REPLY_LEN - 1);
      reply_exp_q.push_back(r);
    end
  endfunction

  // len counts the '$' too
  function automatic void judge_frame(input int unsigned len);
    logic [7:0] id, cmd, addr, data;
    if (len < 6) return;
    id   = held[0];
    cmd  = held[1];
    addr = held[2];
    if (id != own_id_q) return;
    if (cmd == fras_pkg::SYM_WRITE) begin
      data = held[3];
      if (len != 7 || held[4] != 8'(id + cmd + addr + data)) return;
      if (addr < REG_COUNT) regs[addr] = data;
      queue_reply(id, cmd, addr, data);
    end else if (cmd == fras_pkg::SYM_READ) begin
      if (len != 6 || held[3] != 8'(id + cmd + addr)) return;
      data = (addr < REG_COUNT) ? regs[addr] : 8'h00;
      queue_reply(id, cmd, addr, data);
    end
  endfunction

  function automatic void track_rx_byte(input logic [7:0] b);
    if (!rx_active) begin
      if (b == fras_pkg::SYM_START) begin
        rx_active = 1'b1;
        rx_count  = 1;
      end
    end else if (rx_count >= FRAME_LIMIT) begin
      // frame too long: drop it along with this byte
      rx_active = 1'b0;
    end else begin
      if (rx_count >= 1 && rx_count <= fras_pkg::HELD_BYTES) held[rx_count - 1] = b;
      rx_count++;
      if (b == fras_pkg::SYM_NL) begin
        rx_active = 1'b0;
        judge_frame(rx_count);
      end
    end
  endfunction

  task automatic push_byte(input logic [7:0] b);
    rx_stim_q.push_back(b);
    items_pushed++;
  endtask

  task automatic push_cmd(input logic [7:0] id, cmd, addr, data, input bit with_data,
                          input logic [7:0] sum_flip);
    logic [7:0] sum;
    sum = id + cmd + addr + (with_data ? data : 8'h00);
    push_byte(fras_pkg::SYM_START);
    push_byte(id);
    push_byte(cmd);
    push_byte(addr);
    if (with_data) push_byte(data);
    push_byte(sum ^ sum_flip);
    push_byte(fras_pkg::SYM_NL);
  endtask

  task automatic push_random_frame(input logic [7:0] id);
    int           kind;
    int           n;
    frame_fault_t fault;
    logic [7:0]   addr, data, cmd, b;
    kind = $urandom_range(0, 99);
    addr = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                       : 8'($urandom_range(0, REG_COUNT - 1));
    data = 8'($urandom);
    if ($urandom_range(0, 7) == 0) push_byte(8'($urandom));
    if (kind < 40) begin
      push_cmd(id, fras_pkg::SYM_WRITE, addr, data, 1'b1, 8'h00);
    end else if (kind < 75) begin
      push_cmd(id, fras_pkg::SYM_READ, addr, 8'h00, 1'b0, 8'h00);
    end else if (kind < 85) begin
      fault = frame_fault_t'($urandom_range(0, 3));
      case (fault)
        BAD_ID: begin
          push_cmd(id ^ 8'($urandom_range(1, 255)), fras_pkg::SYM_WRITE, addr, data,
                   1'b1, 8'h00);
        end
        BAD_SUM: begin
          if ($urandom_range(0, 1)) begin
            push_cmd(id, fras_pkg::SYM_WRITE, addr, data, 1'b1, 8'($urandom_range(1, 255)));
          end else begin
            push_cmd(id, fras_pkg::SYM_READ, addr, 8'h00, 1'b0, 8'($urandom_range(1, 255)));
          end
        end
        BAD_LEN: begin
          // write without data, or read with an extra data byte
          if ($urandom_range(0, 1)) push_cmd(id, fras_pkg::SYM_WRITE, addr, data, 1'b0, 8'h00);
          else push_cmd(id, fras_pkg::SYM_READ, addr, data, 1'b1, 8'h00);
        end
        default: begin
          cmd = 8'($urandom);
          if (cmd == fras_pkg::SYM_WRITE || cmd == fras_pkg::SYM_READ) cmd = cmd ^ 8'h01;
          push_cmd(id, cmd, addr, data, 1'($urandom_range(0, 1)), 8'h00);
        end
      endcase
    end else if (kind < 92) begin
      // runs up to and past the frame limit
      n = $urandom_range(FRAME_LIMIT - 3, FRAME_LIMIT + 2);
      push_byte(fras_pkg::SYM_START);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom);
        if (b == fras_pkg::SYM_NL) b = 8'h0B;
        if (i == FRAME_LIMIT - 1 && $urandom_range(0, 1)) b = fras_pkg::SYM_START;
        push_byte(b);
      end
      push_byte(fras_pkg::SYM_NL);
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) push_byte(8'($urandom));
      if ($urandom_range(0, 1)) push_byte(fras_pkg::SYM_NL);
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (items_accepted != items_pushed || reply_exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_own_id(input logic [7:0] id);
    @(posedge clk);
    cfg_wr_en        <= 1'b1;
    cfg_own_slave_id <= id;
    own_id_q = id;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (rx_stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_stim_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // model update, reply check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      progress = 1'b0;
      if (in_valid && in_ready) begin
        progress = 1'b1;
        items_accepted++;
        track_rx_byte(in_rx_byte);
      end
      if (out_valid && out_ready) begin
        progress = 1'b1;
        if (reply_exp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected reply item: tx_byte %h tx_last %b",
                     out_tx_byte, out_tx_last);
        end else begin
          reply_exp = reply_exp_q.pop_front();
          if (out_tx_byte !== reply_exp.tx_byte || out_tx_last !== reply_exp.tx_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("reply mismatch: expected tx_byte %h tx_last %b, got %h %b",
                       reply_exp.tx_byte, reply_exp.tx_last, out_tx_byte, out_tx_last);
          end
        end
      end
      if (progress) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("framed_register_access_slave_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  phase_id[5];
    int          idle_pct[5];
    int          stall_pct[5];
    int unsigned phase_start;
    for (int i = 0; i < REG_COUNT; i++) regs[i] = 8'h00;
    for (int i = 0; i < fras_pkg::HELD_BYTES; i++) held[i] = 8'h00;
    phase_id  = '{fras_pkg::ID_AT_RESET, 8'h00, 8'hFF, 8'($urandom_range(2, 254)),
                  fras_pkg::SYM_START};
    idle_pct  = '{0, 56, 0, 6, 0};
    stall_pct = '{0, 0, 56, 6, 0};
    if (phase_id[3] == fras_pkg::SYM_NL) phase_id[3] = 8'h0B;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < 5; p++) begin
      if (p != 0) write_own_id(phase_id[p]);
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      if (p == 0) begin
        push_cmd(own_id_q, fras_pkg::SYM_WRITE, 8'h0F, 8'hFF, 1'b1, 8'h00);
        push_cmd(own_id_q, fras_pkg::SYM_READ, 8'h0F, 8'h00, 1'b0, 8'h00);
        // out-of-range read whose address is a start byte inside the frame
        push_cmd(own_id_q, fras_pkg::SYM_READ, fras_pkg::SYM_START, 8'h00, 1'b0, 8'h00);
        // frame too short to evaluate
        push_byte(fras_pkg::SYM_START);
        push_byte(fras_pkg::SYM_NL);
      end
      phase_start = items_pushed;
      while (items_pushed - phase_start < PHASE_ITEMS) push_random_frame(own_id_q);
      // close any open frame before the next register write
      push_byte(fras_pkg::SYM_NL);
      wait_quiet();
    end

    if (mismatch_count == 0) $display("framed_register_access_slave_top verification clean");
    else $display("framed_register_access_slave_top verification failed");
    $finish;
  end

endmodule
